// File: hw/rtl/phl_pkg.sv
// shared types and constants of the pseudo-huber cost, gradient and hessian block
package phl_pkg;

    localparam int DELTA_W = 31;
    localparam int COST_W  = 63;
    localparam int STEP_W  = 4;

    localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(65536);
    localparam logic [COST_W-1:0]  COST_MAX    = {COST_W{1'b1}};

    // datapath steps, run in this order for every item
    localparam logic [STEP_W-1:0] STEP_DD  = 4'd0;  // d*d
    localparam logic [STEP_W-1:0] STEP_XX  = 4'd1;  // x*x
    localparam logic [STEP_W-1:0] STEP_SQ  = 4'd2;  // r = isqrt(d*d + x*x)
    localparam logic [STEP_W-1:0] STEP_XD  = 4'd3;  // x*d
    localparam logic [STEP_W-1:0] STEP_DG  = 4'd4;  // gradient = x*d / r
    localparam logic [STEP_W-1:0] STEP_CM  = 4'd5;  // d*(r-d)
    localparam logic [STEP_W-1:0] STEP_H1D = 4'd6;  // h1 = (d << frac) / r
    localparam logic [STEP_W-1:0] STEP_H1M = 4'd7;  // h1*d
    localparam logic [STEP_W-1:0] STEP_H2D = 4'd8;  // h2 = h1*d / r
    localparam logic [STEP_W-1:0] STEP_H2M = 4'd9;  // h2*d
    localparam logic [STEP_W-1:0] STEP_H3D = 4'd10; // h3 = h2*d / r

    typedef struct packed {
        logic              load;
        logic              start;
        logic              finish;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

endpackage

// File: hw/rtl/phl_ctrl.sv
// controller: sequences the datapath steps and owns the handshakes
module phl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output phl_pkg::t_dp_cmd    o_cmd,
    input  phl_pkg::t_dp_status i_status
);
    import phl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_issue, n_issue;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;
    logic              w_finish;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_finish    = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load   = w_accept;
    assign o_cmd.start  = r_issue;
    assign o_cmd.finish = w_finish;
    assign o_cmd.step   = r_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_issue = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                    n_step  = STEP_DD;
                    n_issue = 1'b1;
                end
            end
            ST_RUN: begin
                if (i_status.done) begin
                    if (r_step == STEP_H3D) begin
                        n_state = ST_OUT;
                    end else begin
                        n_step  = STEP_W'(r_step + 1'b1);
                        n_issue = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_DD;
            r_issue     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_issue     <= n_issue;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hw/rtl/phl_datapath.sv
// datapath: serial multiplier, divider and square root with operand and result registers
module phl_datapath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [phl_pkg::DELTA_W-1:0] i_cfg_wr_data,
    input  logic [DATA_WIDTH-1:0]       i_residual,
    input  logic                        i_end_of_vector,
    input  phl_pkg::t_dp_cmd            i_cmd,
    output phl_pkg::t_dp_status         o_status,
    output logic [DATA_WIDTH-1:0]       o_gradient,
    output logic [FRAC_BITS:0]          o_hessian_scale,
    output logic [phl_pkg::COST_W-1:0]  o_element_cost,
    output logic [phl_pkg::COST_W-1:0]  o_total_cost,
    output logic                        o_is_final
);
    import phl_pkg::*;

    localparam int RW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int PW   = 2 * RW;
    localparam int QN   = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
    localparam int NMAX = (RW > QN) ? RW : QN;
    localparam int CW   = $clog2(NMAX + 1);
    localparam int RMW  = RW + 3;

    localparam logic [1:0] MODE_MUL  = 2'd0;
    localparam logic [1:0] MODE_DIV  = 2'd1;
    localparam logic [1:0] MODE_SQRT = 2'd2;

    // configuration and accumulator
    logic [DELTA_W-1:0]  r_delta;
    logic [COST_W-1:0]   r_acc;

    // item operands and saved results
    logic [DELTA_W-1:0]    r_d;
    logic [DATA_WIDTH-1:0] r_mag;
    logic                  r_neg;
    logic                  r_fin;
    logic [PW-1:0]         r_dd;
    logic [RW-1:0]         r_r;
    logic [DATA_WIDTH-1:0] r_g;
    logic [COST_W-1:0]     r_cost;

    // shared serial unit
    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done;
    logic [PW-1:0] r_a, n_a;
    logic [RW-1:0] r_b, n_b;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_num, n_num;
    logic [RMW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [QN-1:0] r_quo;

    // output registers
    logic [DATA_WIDTH-1:0] r_out_grad;
    logic [FRAC_BITS:0]    r_out_hess;
    logic [COST_W-1:0]     r_out_cost;
    logic [COST_W-1:0]     r_out_total;
    logic                  r_out_fin;

    logic [RMW-1:0] w_dnr;
    logic [RMW-1:0] w_dvs;
    logic [RMW-1:0] w_snr;
    logic [RMW-1:0] w_trial;
    logic [PW-1:0]  w_cost_full;
    logic [COST_W:0] w_total;

    assign w_dnr   = {2'b00, r_rem[RW-1:0], r_num[QN-1]};
    assign w_dvs   = {3'b000, r_r};
    assign w_snr   = {r_rem[RW:0], r_num[PW-1:PW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_cost_full = r_prod >> FRAC_BITS;
    assign w_total = {1'b0, r_acc} + {1'b0, r_cost};

    // operand set-up for each step
    always_comb begin
        n_mode = MODE_MUL;
        n_a    = '0;
        n_b    = '0;
        n_num  = '0;
        unique case (i_cmd.step) inside
            STEP_DD: begin
                n_a = PW'(r_d);
                n_b = RW'(r_d);
            end
            STEP_XX: begin
                n_a = PW'(r_mag);
                n_b = RW'(r_mag);
            end
            STEP_SQ: begin
                n_mode = MODE_SQRT;
                n_num  = r_dd + r_prod;
            end
            STEP_XD: begin
                n_a = PW'(r_mag);
                n_b = RW'(r_d);
            end
            STEP_DG, STEP_H2D, STEP_H3D: begin
                n_mode = MODE_DIV;
                n_num  = r_prod;
            end
            STEP_CM: begin
                n_a = PW'(r_d);
                n_b = r_r - RW'(r_d);
            end
            STEP_H1D: begin
                n_mode = MODE_DIV;
                n_num  = PW'(r_d) << FRAC_BITS;
            end
            STEP_H1M, STEP_H2M: begin
                n_a = PW'(r_quo);
                n_b = RW'(r_d);
            end
            default: begin
                n_mode = MODE_MUL;
            end
        endcase
        n_cnt = (n_mode == MODE_DIV) ? CW'(QN) : CW'(RW);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= DELTA_RESET;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delta <= i_cfg_wr_data;
            end
            if (i_cmd.finish) begin
                r_acc <= (r_fin) ? '0 : (w_total[COST_W] ? COST_MAX : w_total[COST_W-1:0]);
            end
            r_done <= (r_cnt == CW'(1));
            if (i_cmd.start) begin
                r_cnt <= n_cnt;
            end else if (r_cnt != '0) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_residual[DATA_WIDTH-1];
            r_mag <= i_residual[DATA_WIDTH-1] ? DATA_WIDTH'(-i_residual) : i_residual;
            r_fin <= i_end_of_vector;
            r_d   <= (r_delta == '0) ? DELTA_W'(1) : r_delta;
        end

        if (i_cmd.start) begin
            r_mode <= n_mode;
            r_a    <= n_a;
            r_b    <= n_b;
            r_num  <= n_num;
            case (n_mode)
                MODE_MUL:  r_prod <= '0;
                MODE_DIV:  r_rem  <= RMW'(n_num >> QN);
                default: begin
                    r_rem  <= '0;
                    r_root <= '0;
                end
            endcase
            // keep the result of the step that just ended
            case (i_cmd.step)
                STEP_XX:  r_dd <= r_prod;
                STEP_XD:  r_r  <= (r_root < RW'(r_d)) ? RW'(r_d) : r_root;
                STEP_CM:  r_g  <= r_quo[DATA_WIDTH-1:0];
                STEP_H1D: r_cost <= (|w_cost_full[PW-1:COST_W]) ? COST_MAX
                                                                 : w_cost_full[COST_W-1:0];
                default: begin
                end
            endcase
        end else if (r_cnt != '0) begin
            case (r_mode)
                MODE_MUL: begin
                    if (r_b[0]) begin
                        r_prod <= r_prod + r_a;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
                MODE_DIV: begin
                    if (w_dnr >= w_dvs) begin
                        r_rem <= w_dnr - w_dvs;
                        r_quo <= {r_quo[QN-2:0], 1'b1};
                    end else begin
                        r_rem <= w_dnr;
                        r_quo <= {r_quo[QN-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                end
                default: begin
                    if (w_snr >= w_trial) begin
                        r_rem  <= w_snr - w_trial;
                        r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_snr;
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                    r_num <= r_num << 2;
                end
            endcase
        end

        if (i_cmd.finish) begin
            r_out_grad  <= r_neg ? DATA_WIDTH'(-r_g) : r_g;
            r_out_hess  <= r_quo[FRAC_BITS:0];
            r_out_cost  <= r_cost;
            r_out_total <= w_total[COST_W] ? COST_MAX : w_total[COST_W-1:0];
            r_out_fin   <= r_fin;
        end
    end

    assign o_status.done   = r_done;
    assign o_gradient      = r_out_grad;
    assign o_hessian_scale = r_out_hess;
    assign o_element_cost  = r_out_cost;
    assign o_total_cost    = r_out_total;
    assign o_is_final      = r_out_fin;

endmodule

// File: hw/rtl/pseudo_huber_loss_grad_hess_top.sv
// an item runs through 11 serial steps on one shared unit; multiply and square root work
// on max(DATA_WIDTH,32) bits, divide on max(DATA_WIDTH,FRAC_BITS+1) quotient bits
// the unit works one bit per cycle; no new item is taken until the last one has finished
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active low) sets delta to 1.0, clears the cost sum and the handshakes
module pseudo_huber_loss_grad_hess_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [phl_pkg::DELTA_W-1:0] i_cfg_wr_data,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // residual
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // end_of_vector
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // gradient, hessian_scale, element_cost, total_cost
    output logic [((DATA_WIDTH+FRAC_BITS+1+2*phl_pkg::COST_W+7)/8)*8-1:0] o_m_axis_tdata,
    // is_final
    output logic                        o_m_axis_tlast
);
    import phl_pkg::*;

    localparam int OUT_BITS = DATA_WIDTH + FRAC_BITS + 1 + 2 * COST_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    logic [DATA_WIDTH-1:0] w_gradient;
    logic [FRAC_BITS:0]    w_hessian_scale;
    logic [COST_W-1:0]     w_element_cost;
    logic [COST_W-1:0]     w_total_cost;

    phl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    phl_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_residual      (i_s_axis_tdata[DATA_WIDTH-1:0]),
        .i_end_of_vector (i_s_axis_tlast),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_gradient      (w_gradient),
        .o_hessian_scale (w_hessian_scale),
        .o_element_cost  (w_element_cost),
        .o_total_cost    (w_total_cost),
        .o_is_final      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'({w_total_cost, w_element_cost, w_hessian_scale, w_gradient});

endmodule
